>>> rtl/gkg_pkg.sv
package gkg_pkg;

  // Fixed field widths
  localparam int FUNC_W = 2;
  localparam int NODE_W = 6;
  localparam int ROW_W  = 64;
  localparam int K_W    = 7;

  // Default node capacity
  localparam int MAX_NODES_DEF = 64;

  // Reset value of k
  localparam logic [K_W-1:0] K_RESET = K_W'(1);

  // Input function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_ROW    = 2'd0,
    FN_MEMBER = 2'd1,
    FN_CAND   = 2'd2,
    FN_START  = 2'd3
  } func_t;

  // Member list read address source
  typedef enum logic [1:0] {
    MS_SZ,
    MS_Q,
    MS_OUT
  } msel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  in_ready;
    logic  load;
    logic  begin_run;
    logic  mem_rd;
    msel_t mem_sel;
    logic  x_from_mem;
    logic  x_from_cand;
    logic  cand_rd;
    logic  adj_rd_x;
    logic  adj_rd_deg;
    logic  row_load;
    logic  sw_restart;
    logic  sw_eval;
    logic  sw_write;
    logic  sw_check;
    logic  commit_init;
    logic  commit_grow;
    logic  scan_next;
    logic  out_start;
    logic  out_load;
    logic  clear_lists;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sz_lt_mcount;
    logic q_lt_sz;
    logic fits;
    logic c_lt_ccount;
    logic c_removed;
    logic sz_full;
    logic out_free;
    logic out_last;
  } stat_t;

endpackage

>>> rtl/gkg_in_if.sv
interface gkg_in_if;
  import gkg_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] node;
  logic [ROW_W-1:0]  row_bits;

  modport source (output valid, func, node, row_bits, input ready);
  modport sink (input valid, func, node, row_bits, output ready);
endinterface

>>> rtl/gkg_out_if.sv
interface gkg_out_if;
  import gkg_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] member;
  logic              member_valid;
  logic              last;

  modport source (output valid, member, member_valid, last, input ready);
  modport sink (input valid, member, member_valid, last, output ready);
endinterface

>>> rtl/gkg_ctrl.sv
module gkg_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [gkg_pkg::FUNC_W-1:0] in_func,
  input  gkg_pkg::stat_t             st,
  output gkg_pkg::cmd_t              cmd
);
  import gkg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_TEST,
    S_INIT_RD,
    S_X_LOAD_MEM,
    S_CAND_RD,
    S_X_LOAD_CAND,
    S_ROW_RD,
    S_ROW_LOAD,
    S_SW_TEST,
    S_SW_MEM,
    S_SW_ADJ,
    S_SW_EVAL,
    S_SW_DONE,
    S_SCAN,
    S_OUT_RD,
    S_OUT_LD
  } state_t;

  // What the current member sweep is for
  typedef enum logic [1:0] {
    K_INIT,
    K_CHECK,
    K_COMMIT
  } kind_t;

  state_t state, state_next;
  kind_t  kind, kind_next;

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    kind_next  = kind;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FN_START) begin
            cmd.begin_run = 1'b1;
            state_next    = S_INIT_TEST;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      // seed degrees are built by replaying each seed as an add
      S_INIT_TEST: begin
        if (st.sz_lt_mcount) begin
          state_next = S_INIT_RD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_INIT_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.mem_sel = MS_SZ;
        state_next  = S_X_LOAD_MEM;
      end
      S_X_LOAD_MEM: begin
        cmd.x_from_mem = 1'b1;
        kind_next      = K_INIT;
        state_next     = S_ROW_RD;
      end
      S_CAND_RD: begin
        cmd.cand_rd = 1'b1;
        state_next  = S_X_LOAD_CAND;
      end
      S_X_LOAD_CAND: begin
        cmd.x_from_cand = 1'b1;
        kind_next       = K_CHECK;
        state_next      = S_ROW_RD;
      end
      S_ROW_RD: begin
        cmd.adj_rd_x = 1'b1;
        state_next   = S_ROW_LOAD;
      end
      S_ROW_LOAD: begin
        cmd.row_load = 1'b1;
        state_next   = S_SW_TEST;
      end
      // sweep over the current members: test, member read, degree read, evaluate
      S_SW_TEST: begin
        if (st.q_lt_sz) begin
          state_next = S_SW_MEM;
        end else begin
          state_next = S_SW_DONE;
        end
      end
      S_SW_MEM: begin
        cmd.mem_rd  = 1'b1;
        cmd.mem_sel = MS_Q;
        state_next  = S_SW_ADJ;
      end
      S_SW_ADJ: begin
        cmd.adj_rd_deg = 1'b1;
        state_next     = S_SW_EVAL;
      end
      S_SW_EVAL: begin
        cmd.sw_eval  = 1'b1;
        cmd.sw_write = (kind != K_CHECK);
        cmd.sw_check = (kind == K_CHECK);
        state_next   = S_SW_TEST;
      end
      S_SW_DONE: begin
        case (kind)
          K_INIT: begin
            cmd.commit_init = 1'b1;
            state_next      = S_INIT_TEST;
          end
          K_CHECK: begin
            if (st.fits) begin
              cmd.sw_restart = 1'b1;
              kind_next      = K_COMMIT;
              state_next     = S_SW_TEST;
            end else begin
              cmd.scan_next = 1'b1;
              state_next    = S_SCAN;
            end
          end
          K_COMMIT: begin
            cmd.commit_grow = 1'b1;
            state_next      = S_SCAN;
          end
          default: state_next = S_IDLE;
        endcase
      end
      // walk the candidate list, skipping taken entries
      S_SCAN: begin
        if (st.sz_full || !st.c_lt_ccount) begin
          cmd.out_start = 1'b1;
          state_next    = S_OUT_RD;
        end else if (st.c_removed) begin
          cmd.scan_next = 1'b1;
        end else begin
          state_next = S_CAND_RD;
        end
      end
      S_OUT_RD: begin
        cmd.mem_rd  = 1'b1;
        cmd.mem_sel = MS_OUT;
        state_next  = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.out_last) begin
            cmd.clear_lists = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_INIT;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

endmodule

>>> rtl/gkg_dp.sv
module gkg_dp #(
  parameter int MAX_NODES = gkg_pkg::MAX_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gkg_pkg::cmd_t              cmd,
  output gkg_pkg::stat_t             st,
  input  logic [gkg_pkg::FUNC_W-1:0] in_func,
  input  logic [gkg_pkg::NODE_W-1:0] in_node,
  input  logic [gkg_pkg::ROW_W-1:0]  in_row_bits,
  input  logic                       cfg_wen,
  input  logic [gkg_pkg::K_W-1:0]    cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gkg_pkg::NODE_W-1:0] out_member,
  output logic                       out_mvalid,
  output logic                       out_last
);
  import gkg_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = K_W + 1;

  // Storage
  logic [ROW_W-1:0]  adj_mem    [MAX_NODES];
  logic [NODE_W-1:0] member_mem [MAX_NODES];
  logic [NODE_W-1:0] cand_mem   [MAX_NODES];
  logic [CNT_W-1:0]  deg_mem    [MAX_NODES];

  logic [ROW_W-1:0]     adj_q;
  logic [NODE_W-1:0]    member_q;
  logic [NODE_W-1:0]    cand_q;
  logic [CNT_W-1:0]     deg_q;

  // Run state
  logic [K_W-1:0]       k;
  logic [CNT_W-1:0]     mcount;
  logic [CNT_W-1:0]     ccount;
  logic [MAX_NODES-1:0] removed;
  logic [CNT_W-1:0]     sz;
  logic [CNT_W-1:0]     q;
  logic [CNT_W-1:0]     c;
  logic [CNT_W-1:0]     oidx;
  logic [NODE_W-1:0]    x;
  logic [ROW_W-1:0]     xrow;
  logic [CNT_W-1:0]     acc;
  logic                 fail;

  logic                 node_ok;
  logic                 row_we;
  logic                 member_we;
  logic                 cand_we;
  logic [IDX_W-1:0]     mem_raddr;
  logic [CNT_W-1:0]     dsum;
  logic                 dfail;
  logic [CNT_W:0]       oidx_inc;
  logic [NODE_W-1:0]    node_idx;

  // Load item decode
  assign node_ok   = (NODE_W+1)'(in_node) < (NODE_W+1)'(MAX_NODES);
  assign node_idx  = in_node;
  assign row_we    = cmd.load && (in_func == FN_ROW) && node_ok;
  assign member_we = cmd.load && (in_func == FN_MEMBER) && node_ok &&
                     (mcount < CNT_W'(MAX_NODES));
  assign cand_we   = cmd.load && (in_func == FN_CAND) && node_ok &&
                     (ccount < CNT_W'(MAX_NODES));

  // Member list read address
  always_comb begin
    case (cmd.mem_sel)
      MS_SZ:   mem_raddr = sz[IDX_W-1:0];
      MS_Q:    mem_raddr = q[IDX_W-1:0];
      MS_OUT:  mem_raddr = oidx[IDX_W-1:0];
      default: mem_raddr = q[IDX_W-1:0];
    endcase
  end

  // Degree of member q with x included, and its bound check
  assign dsum  = deg_q + CNT_W'(adj_q[x]);
  assign dfail = (CMP_W'(dsum) + CMP_W'(k)) < (CMP_W'(sz) + CMP_W'(1));

  // Status
  assign oidx_inc        = (CNT_W+1)'(oidx) + (CNT_W+1)'(1);
  assign st.sz_lt_mcount = sz < mcount;
  assign st.q_lt_sz      = q < sz;
  assign st.fits         = !fail &&
                           ((CMP_W'(acc) + CMP_W'(k)) >= (CMP_W'(sz) + CMP_W'(1)));
  assign st.c_lt_ccount  = c < ccount;
  assign st.c_removed    = removed[c[IDX_W-1:0]];
  assign st.sz_full      = sz == CNT_W'(MAX_NODES);
  assign st.out_free     = !out_valid || out_ready;
  assign st.out_last     = oidx_inc >= (CNT_W+1)'(mcount);

  // Adjacency rows
  always_ff @(posedge clk) begin
    if (row_we) begin
      adj_mem[node_idx[IDX_W-1:0]] <= in_row_bits;
    end
    if (cmd.adj_rd_x) begin
      adj_q <= adj_mem[x[IDX_W-1:0]];
    end else if (cmd.adj_rd_deg) begin
      adj_q <= adj_mem[member_q[IDX_W-1:0]];
    end
  end

  // Member list
  always_ff @(posedge clk) begin
    if (member_we) begin
      member_mem[mcount[IDX_W-1:0]] <= in_node;
    end else if (cmd.commit_grow) begin
      member_mem[sz[IDX_W-1:0]] <= x;
    end
    if (cmd.mem_rd) begin
      member_q <= member_mem[mem_raddr];
    end
  end

  // Candidate list
  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[ccount[IDX_W-1:0]] <= in_node;
    end
    if (cmd.cand_rd) begin
      cand_q <= cand_mem[c[IDX_W-1:0]];
    end
  end

  // In-set degree per member entry
  always_ff @(posedge clk) begin
    if (cmd.sw_eval && cmd.sw_write) begin
      deg_mem[q[IDX_W-1:0]] <= dsum;
    end else if (cmd.commit_init || cmd.commit_grow) begin
      deg_mem[sz[IDX_W-1:0]] <= acc;
    end
    if (cmd.adj_rd_deg) begin
      deg_q <= deg_mem[q[IDX_W-1:0]];
    end
  end

  // Sweep and scan registers
  always_ff @(posedge clk) begin
    if (cmd.begin_run) begin
      sz <= '0;
      c  <= '0;
    end
    if (cmd.x_from_mem) begin
      x <= member_q;
    end else if (cmd.x_from_cand) begin
      x <= cand_q;
    end
    if (cmd.row_load) begin
      xrow <= adj_q;
      acc  <= CNT_W'(adj_q[x]);
      q    <= '0;
      fail <= 1'b0;
    end
    if (cmd.sw_restart) begin
      acc <= CNT_W'(xrow[x]);
      q   <= '0;
    end
    if (cmd.sw_eval) begin
      acc <= acc + CNT_W'(xrow[member_q]);
      q   <= q + CNT_W'(1);
      if (cmd.sw_check && dfail) begin
        fail <= 1'b1;
      end
    end
    if (cmd.commit_init) begin
      sz <= sz + CNT_W'(1);
    end
    if (cmd.commit_grow) begin
      sz <= sz + CNT_W'(1);
      c  <= '0;
    end
    if (cmd.scan_next) begin
      c <= c + CNT_W'(1);
    end
    if (cmd.out_start) begin
      oidx <= '0;
    end
    if (cmd.out_load) begin
      oidx       <= oidx_inc[CNT_W-1:0];
      out_member <= (mcount == '0) ? '0 : member_q;
      out_mvalid <= (mcount != '0);
      out_last   <= st.out_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= K_RESET;
      mcount    <= '0;
      ccount    <= '0;
      removed   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        k <= cfg_wdata;
      end
      if (member_we) begin
        mcount <= mcount + CNT_W'(1);
      end
      if (cand_we) begin
        ccount <= ccount + CNT_W'(1);
      end
      if (cmd.commit_grow) begin
        mcount                 <= mcount + CNT_W'(1);
        removed[c[IDX_W-1:0]]  <= 1'b1;
      end
      if (cmd.clear_lists) begin
        mcount  <= '0;
        ccount  <= '0;
        removed <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (mcount <= CNT_W'(MAX_NODES)) && (ccount <= CNT_W'(MAX_NODES)))
    else $error("list count above capacity");

  a_grow_at_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_grow |-> (sz == mcount) && (sz < CNT_W'(MAX_NODES)))
    else $error("growth commit not at member list tail");

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.sw_eval |-> (q < sz))
    else $error("sweep index past set size");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

>>> rtl/greedy_kplex_grower.sv
// Load transactions (row, seed, candidate) are accepted back to back while idle.
// A start transaction is handled alone: the seeds are first replayed to build
// their degrees, then each candidate not yet taken is tried in a sweep over the
// members and an accepted one is swept again to commit it; results then follow
// one member at a time as the receiver takes them. Reset clears both list counts,
// the taken-candidate bits, the output and the controller, sets k to 1; rows and entries stay as is.
module greedy_kplex_grower #(
  parameter int MAX_NODES = gkg_pkg::MAX_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  gkg_in_if.sink                  item,
  gkg_out_if.source               result,
  input  logic                    cfg_wen,
  input  logic [gkg_pkg::K_W-1:0] cfg_wdata
);
  import gkg_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign item.ready = cmd.in_ready;

  // Sequencer
  gkg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_func  (item.func),
    .st       (st),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  gkg_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_func     (item.func),
    .in_node     (item.node),
    .in_row_bits (item.row_bits),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_member  (result.member),
    .out_mvalid  (result.member_valid),
    .out_last    (result.last)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import gkg_pkg::*;

  localparam int     NODES         = MAX_NODES_DEF;
  localparam int     RANDOM_ITEMS  = 200;
  localparam int     SETTLE_CYCLES = 16;
  localparam int     END_CYCLES    = 40;
  localparam longint CYCLE_LIMIT   = 2_000_000;

  // One emitted member as the checker expects it
  typedef struct packed {
    logic [NODE_W-1:0] member;
    logic              member_valid;
    logic              last;
  } member_rec_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_wen = 1'b0;
  logic [K_W-1:0] cfg_wdata = '0;

  gkg_in_if  item_if ();
  gkg_out_if res_if ();

  greedy_kplex_grower dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_if),
    .result    (res_if),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: graph, both lists and k
  logic [ROW_W-1:0]  adj_rows [NODES];
  logic [NODE_W-1:0] member_ids [NODES];
  logic [NODE_W-1:0] cand_ids [NODES];
  int                member_cnt;
  int                cand_cnt;
  logic [K_W-1:0]    k_cur;

  member_rec_t expected_members [$];

  int     fail_count = 0;
  int     items_sent = 0;
  int     runs_started = 0;
  int     results_seen = 0;
  longint cycle_count = 0;
  bit     quiet = 1'b0;  // no idling on either side while set

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_members.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  // Queue one expected result at the tail
  function automatic void expect_member(member_rec_t rec);
    expected_members = {expected_members, rec};
  endfunction

  // Every member's in-set degree (diagonal counted) must reach size - k
  function automatic bit set_is_kplex();
    int                need;
    int                deg;
    logic [ROW_W-1:0]  row;
    need = member_cnt - int'(k_cur);
    for (int q = 0; q < member_cnt; q++) begin
      row = adj_rows[member_ids[q]];
      deg = 0;
      for (int p = 0; p < member_cnt; p++)
        if (row[member_ids[p]]) deg++;
      if (deg < need) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First fitting candidate in list order joins the set and leaves the list
  function automatic bit take_first_fit();
    if (member_cnt >= NODES) return 1'b0;
    for (int c = 0; c < cand_cnt; c++) begin
      member_ids[member_cnt] = cand_ids[c];
      member_cnt++;
      if (set_is_kplex()) begin
        for (int i = c; i < cand_cnt - 1; i++) cand_ids[i] = cand_ids[i + 1];
        cand_cnt--;
        return 1'b1;
      end
      member_cnt--;
    end
    return 1'b0;
  endfunction

  function automatic void predict_growth();
    member_rec_t rec;
    while (take_first_fit()) begin
    end
    if (member_cnt == 0) begin
      rec = '{member: '0, member_valid: 1'b0, last: 1'b1};
      expect_member(rec);
    end else begin
      for (int i = 0; i < member_cnt; i++) begin
        rec = '{member: member_ids[i], member_valid: 1'b1, last: (i == member_cnt - 1)};
        expect_member(rec);
      end
    end
    member_cnt = 0;
    cand_cnt = 0;
  endfunction

  function automatic void predict_item(func_t fn, logic [NODE_W-1:0] nd,
                                       logic [ROW_W-1:0] bits);
    case (fn)
      FN_ROW: adj_rows[nd] = bits;
      FN_MEMBER: begin
        if (member_cnt < NODES) begin
          member_ids[member_cnt] = nd;
          member_cnt++;
        end
      end
      FN_CAND: begin
        if (cand_cnt < NODES) begin
          cand_ids[cand_cnt] = nd;
          cand_cnt++;
        end
      end
      FN_START: begin
        runs_started++;
        predict_growth();
      end
      default: ;
    endcase
  endfunction

  // Drive one input transaction; prediction happens at the accepting edge
  task automatic send_item(input func_t fn, input logic [NODE_W-1:0] nd,
                           input logic [ROW_W-1:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.func     = fn;
    item_if.node     = nd;
    item_if.row_bits = bits;
    item_if.valid    = 1'b1;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    predict_item(fn, nd, bits);
    items_sent++;
    @(negedge clk);
    item_if.valid = 1'b0;
  endtask

  task automatic start_run();
    send_item(FN_START, NODE_W'($urandom), {$urandom, $urandom});
  endtask

  // Wait for all results, then let the list clear finish
  task automatic wait_idle();
    while (expected_members.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_k(input logic [K_W-1:0] value);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
    k_cur   = value;
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return a & b;
      1:       return a;
      default: return a | b;
    endcase
  endfunction

  // Mostly nodes near a base so that ids repeat within a run
  function automatic logic [NODE_W-1:0] pick_node(logic [NODE_W-1:0] base);
    if ($urandom_range(0, 4) == 0) return NODE_W'($urandom_range(0, NODES - 1));
    return base + NODE_W'($urandom_range(0, 7));
  endfunction

  // Every row gets written before any growth reads it
  task automatic test_load_rows();
    for (int i = 0; i < NODES; i++) begin
      if (i == 0)              send_item(FN_ROW, NODE_W'(i), '0);
      else if (i == NODES - 1) send_item(FN_ROW, NODE_W'(i), '1);
      else                     send_item(FN_ROW, NODE_W'(i), rand_row());
    end
  endtask

  task automatic test_empty_start();
    start_run();
    wait_idle();
  endtask

  // No seeds: first candidate always fits, later ones depend on rows
  task automatic test_candidates_only();
    send_item(FN_CAND, 6'd0, '0);
    send_item(FN_CAND, 6'd63, '0);
    send_item(FN_CAND, 6'd0, '0);
    start_run();
    wait_idle();
  endtask

  // Repeated ids count once per entry; row 5 rewritten to a full row
  task automatic test_duplicates();
    send_item(FN_ROW, 6'd5, '1);
    send_item(FN_MEMBER, 6'd63, '0);
    send_item(FN_MEMBER, 6'd63, '0);
    send_item(FN_CAND, 6'd63, '0);
    send_item(FN_CAND, 6'd5, '0);
    send_item(FN_CAND, 6'd0, '0);
    start_run();
    wait_idle();
  endtask

  // k of zero needs full adjacency; k of 64 and 127 accepts everything
  task automatic test_k_extremes();
    write_k(K_W'(0));
    send_item(FN_MEMBER, 6'd63, '0);
    send_item(FN_CAND, 6'd0, '0);
    send_item(FN_CAND, 6'd63, '0);
    start_run();
    wait_idle();
    write_k(K_W'(127));
    send_item(FN_MEMBER, 6'd0, '0);
    send_item(FN_CAND, 6'd0, '0);
    send_item(FN_CAND, 6'd5, '0);
    start_run();
    wait_idle();
    write_k(K_W'(64));
    send_item(FN_MEMBER, 6'd7, '0);
    send_item(FN_CAND, 6'd0, '0);
    send_item(FN_CAND, 6'd9, '0);
    start_run();
    wait_idle();
  endtask

  // 65 seeds: last append dropped, growth cannot add to a full set
  task automatic test_full_member_list();
    write_k(K_W'(1));
    for (int i = 0; i <= NODES; i++) send_item(FN_MEMBER, NODE_W'(i), '0);
    send_item(FN_CAND, 6'd7, '0);
    start_run();
    wait_idle();
  endtask

  // 65 candidates with k = 64: growth fills the set, leftovers are cleared
  task automatic test_full_candidate_list();
    write_k(K_W'(64));
    send_item(FN_MEMBER, 6'd63, '0);
    send_item(FN_MEMBER, 6'd0, '0);
    for (int i = 0; i <= NODES; i++) send_item(FN_CAND, NODE_W'(i), '0);
    start_run();
    wait_idle();
  endtask

  // Random runs: row rewrites, seeds and candidates interleaved, then a start
  task automatic test_random_growth();
    int                first_item;
    int                runs;
    int                nr;
    int                ns;
    int                nc;
    int                pick;
    logic [NODE_W-1:0] base;
    first_item = items_sent;
    runs = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (runs % 6 == 5) begin
        wait_idle();
        case ($urandom_range(0, 7))
          0:       write_k(K_W'(0));
          1:       write_k(K_W'(64));
          2:       write_k(K_W'(127));
          default: write_k(K_W'($urandom_range(1, 4)));
        endcase
      end
      quiet = ($urandom_range(0, 4) == 0);
      base = NODE_W'($urandom);
      nr = $urandom_range(0, 2);
      ns = $urandom_range(0, 4);
      nc = $urandom_range(0, 8);
      if ($urandom_range(0, 14) == 0) begin
        ns = $urandom_range(5, 12);
        nc = $urandom_range(8, 16);
      end
      while (nr + ns + nc > 0) begin
        pick = $urandom_range(1, nr + ns + nc);
        if (pick <= nr) begin
          send_item(FN_ROW, pick_node(base), rand_row());
          nr--;
        end else if (pick <= nr + ns) begin
          send_item(FN_MEMBER, pick_node(base), {$urandom, $urandom});
          ns--;
        end else begin
          send_item(FN_CAND, pick_node(base), {$urandom, $urandom});
          nc--;
        end
      end
      // occasionally skip the start so lists carry into the next run
      if ($urandom_range(0, 9) != 0) start_run();
      runs++;
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  // Result checker with random backpressure
  initial begin : result_checker
    member_rec_t exp_rec;
    int          stall;
    res_if.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = pick_gap();
      res_if.ready = 1'b0;
      repeat (stall) @(negedge clk);
      res_if.ready = 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      results_seen++;
      if (expected_members.size() == 0) begin
        $error("unexpected result transaction: member %0d member_valid %0b last %0b",
               res_if.member, res_if.member_valid, res_if.last);
        fail_count++;
      end else begin
        exp_rec = expected_members.pop_front();
        if (res_if.member !== exp_rec.member) begin
          $error("member: expected %0d, actual %0d", exp_rec.member, res_if.member);
          fail_count++;
        end
        if (res_if.member_valid !== exp_rec.member_valid) begin
          $error("member_valid: expected %0b, actual %0b",
                 exp_rec.member_valid, res_if.member_valid);
          fail_count++;
        end
        if (res_if.last !== exp_rec.last) begin
          $error("last: expected %0b, actual %0b", exp_rec.last, res_if.last);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Test sequence
  initial begin
    item_if.valid    = 1'b0;
    item_if.func     = FN_ROW;
    item_if.node     = '0;
    item_if.row_bits = '0;
    member_cnt = 0;
    cand_cnt   = 0;
    k_cur      = K_RESET;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_load_rows();
    test_empty_start();
    test_candidates_only();
    test_duplicates();
    test_k_extremes();
    test_full_member_list();
    test_full_candidate_list();
    test_random_growth();

    repeat (END_CYCLES) @(negedge clk);
    $display("Sent %0d input transactions including %0d growth starts; checked %0d results.",
             items_sent, runs_started, results_seen);
    $display("k covered 0, 1, 64, 127 and small values; full lists and empty sets included.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
